FILE: rtl/core/ocu_pkg.sv
// Shared constants, types and helpers of the running mean/covariance update.
package ocu_pkg;

  localparam int DIM_DEF = 4;
  localparam int VAL_W   = 32;
  localparam int CNT_W   = 16;
  localparam int DIV_W   = 48;
  localparam int WIDE_W  = 81;

  localparam logic [1:0] FN_SAMPLE = 2'd0;
  localparam logic [1:0] FN_MEAN   = 2'd1;
  localparam logic [1:0] FN_COV    = 2'd2;

  localparam logic KIND_MEAN = 1'b0;
  localparam logic KIND_COV  = 1'b1;

  typedef struct packed {
    logic              start;
    logic [DIV_W-1:0]  dividend;
    logic [CNT_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DIV_W-1:0]  quot;
    logic              rem_nz;
  } div_res_t;

  // clamp a wide signed value to the signed 32-bit range
  function automatic logic signed [VAL_W-1:0] sat32(input logic signed [WIDE_W-1:0] v);
    logic signed [WIDE_W-1:0] hi;
    logic signed [WIDE_W-1:0] lo;
    hi = WIDE_W'(64'sd2147483647);
    lo = -WIDE_W'(64'sd2147483648);
    if (v > hi) return VAL_W'(32'h7fffffff);
    else if (v < lo) return VAL_W'(32'h80000000);
    else return v[VAL_W-1:0];
  endfunction

endpackage

FILE: rtl/core/ocu_div.sv
// Restoring divider, one quotient bit per cycle, unsigned operands.
module ocu_div (
  input  logic               clk,
  input  logic               rst_n,
  input  ocu_pkg::div_req_t  req,
  output ocu_pkg::div_res_t  res
);

  localparam int DW = ocu_pkg::DIV_W;
  localparam int VW = ocu_pkg::CNT_W;
  localparam int CW = $clog2(DW + 1);

  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [DW-1:0] q_r, q_nxt;
  logic [VW-1:0] rem_r, rem_nxt;
  logic [VW-1:0] d_r, d_nxt;
  logic [VW:0]   sh;
  logic          ge;

  assign sh = {rem_r, q_r[DW-1]};
  assign ge = sh >= {1'b0, d_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    d_nxt    = d_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CW'(DW);
      q_nxt    = req.dividend;
      rem_nxt  = '0;
      d_nxt    = req.divisor;
    end else if (busy_r) begin
      q_nxt   = {q_r[DW-2:0], ge};
      rem_nxt = ge ? VW'(sh - {1'b0, d_r}) : sh[VW-1:0];
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    d_r   <= d_nxt;
  end

  assign res.done   = done_r;
  assign res.quot   = q_r;
  assign res.rem_nz = (rem_r != '0);

endmodule

FILE: rtl/core/online_mean_covariance_update.sv
// Running mean and covariance update in signed Q16.16 with a shared multiplier and divider.
//
// Input channel (in_*): one request per element. func selects a sample
// element, a mean preset or a covariance preset. A preset is written at its
// accepting edge and in_ready stays high, so presets can follow back to back.
// A sample element holds in_ready low from acceptance until its update is written:
// one 48-step serial divide by n, one quotient bit a cycle in the shared divider.
// On the element flagged last the block then walks all DIM*DIM covariance
// entries; each entry takes four passes through the shared 33x33 multiplier,
// a start state and one 48-step serial divide by n-1, and each row first
// loads its deviation in a state of its own.
// Then DIM mean entries and DIM*DIM covariance entries (row-major) leave on the
// result channel (out_*), one per cycle while out_ready is high; final_entry
// marks the last. in_ready is high only while nothing is in progress.
// A stalled receiver holds the result register and pauses the emission.
// Reset clears the mean and covariance stores and the control state.
module online_mean_covariance_update #(
  parameter int DIM = ocu_pkg::DIM_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_func,
  input  logic [1:0]  in_row,
  input  logic [1:0]  in_col,
  input  logic signed [31:0] in_value,
  input  logic [15:0] in_sample_count,
  input  logic        in_last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_kind,
  output logic [1:0]  out_row,
  output logic [1:0]  out_col,
  output logic signed [31:0] out_value,
  output logic        out_final_entry
);

  localparam int IW = (DIM > 1) ? $clog2(DIM) : 1;
  localparam int VW = ocu_pkg::VAL_W;
  localparam int NW = ocu_pkg::CNT_W;
  localparam int DW = ocu_pkg::DIV_W;
  localparam int WW = ocu_pkg::WIDE_W;

  typedef enum logic [10:0] {
    ST_IDLE   = 11'b00000000001,
    ST_SDIV   = 11'b00000000010,
    ST_LDU    = 11'b00000000100,
    ST_MUU    = 11'b00000001000,
    ST_MPH    = 11'b00000010000,
    ST_MPL    = 11'b00000100000,
    ST_MSN    = 11'b00001000000,
    ST_CSTART = 11'b00010000000,
    ST_CDIV   = 11'b00100000000,
    ST_EMEAN  = 11'b01000000000,
    ST_ECOV   = 11'b10000000000
  } state_t;

  state_t state_r, state_nxt;

  logic signed [VW-1:0] mean_r [DIM];
  logic signed [VW-1:0] cov_r  [DIM][DIM];
  logic signed [VW-1:0] dev_r  [DIM];

  logic [IW-1:0] i_r, i_nxt, j_r, j_nxt, row_r, row_nxt;
  logic [NW-1:0] n_r, n_nxt;
  logic          last_r, last_nxt;
  logic          neg_r, neg_nxt;
  logic signed [VW-1:0] ui_r, ui_nxt;
  logic [VW-1:0]        pl_r, pl_nxt;
  logic signed [48:0]   hi_r, hi_nxt;
  logic [47:0]          lo_r, lo_nxt;
  logic signed [WW-1:0] t2_r, t2_nxt;
  logic signed [65:0]   prod_r;

  logic signed [32:0] mul_a, mul_b;
  logic [IW-1:0]      mean_addr, dev_addr;
  logic signed [VW-1:0] mean_rd, dev_rd, cov_rd;

  logic          out_valid_r, out_valid_nxt, out_kind_r, out_kind_nxt;
  logic [1:0]    out_row_r, out_row_nxt, out_col_r, out_col_nxt;
  logic signed [VW-1:0] out_value_r, out_value_nxt;
  logic          out_final_r, out_final_nxt;

  ocu_pkg::div_req_t div_req;
  ocu_pkg::div_res_t div_res;

  logic [NW-1:0]        n_in;
  logic                 in_row_ok, in_cov_ok, accept, slot_free;
  logic signed [32:0]   diff;
  logic [32:0]          diff_mag;
  logic signed [48:0]   q_s;
  logic signed [WW-1:0] u_w, mean_w, t1_w, tot_w, sum81;
  logic signed [VW-1:0] u_val;
  logic [47:0]          prod_mag;
  logic                 mean_we, dev_we, cov_we, cov_pre_we, mean_pre_we;
  logic signed [VW-1:0] mean_wd, cov_wd;
  logic [IW-1:0]        mean_wa;

  ocu_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .res   (div_res)
  );

  assign n_in      = (in_sample_count < NW'(2)) ? NW'(2) : in_sample_count;
  assign in_row_ok = int'(in_row) < DIM;
  assign in_cov_ok = in_row_ok && (int'(in_col) < DIM);
  assign in_ready  = (state_r == ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign slot_free = !out_valid_r || out_ready;

  assign mean_addr = (state_r == ST_IDLE) ? IW'(in_row) :
                     (state_r == ST_SDIV) ? row_r : i_r;
  assign mean_rd   = mean_r[mean_addr];
  assign dev_addr  = (state_r == ST_MUU) ? j_r : i_r;
  assign dev_rd    = dev_r[dev_addr];
  assign cov_rd    = cov_r[i_r][j_r];

  assign diff     = 33'(in_value) - 33'(mean_rd);
  assign diff_mag = diff[32] ? 33'(-diff) : 33'(diff);
  assign prod_mag = prod_r[65] ? 48'(-prod_r) : prod_r[47:0];

  // signed quotient: truncated for the sample, floored for the covariance scale
  assign q_s    = neg_r ? -$signed({1'b0, div_res.quot}) : $signed({1'b0, div_res.quot});
  assign u_w    = WW'(q_s);
  assign u_val  = ocu_pkg::sat32(u_w);
  assign mean_w = WW'(mean_rd) + WW'(u_val);
  assign t1_w   = (neg_r && div_res.rem_nz) ? WW'(q_s) - WW'(1) : WW'(q_s);
  assign tot_w  = t1_w + t2_r;
  assign sum81  = $signed({hi_r, 32'b0}) + $signed({33'b0, lo_r});

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      ST_MUU: begin
        mul_a = 33'(ui_r);
        mul_b = 33'(dev_rd);
      end
      ST_MPH: begin
        // upper half of the product is signed
        mul_a = 33'($signed(prod_r[63:32]));
        mul_b = $signed({17'b0, n_r});
      end
      ST_MPL: begin
        mul_a = $signed({1'b0, pl_r});
        mul_b = $signed({17'b0, n_r});
      end
      ST_MSN: begin
        mul_a = 33'(cov_rd);
        mul_b = $signed({17'b0, NW'(n_r - NW'(2))});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    row_nxt   = row_r;
    n_nxt     = n_r;
    last_nxt  = last_r;
    neg_nxt   = neg_r;
    ui_nxt    = ui_r;
    pl_nxt    = pl_r;
    hi_nxt    = hi_r;
    lo_nxt    = lo_r;
    t2_nxt    = t2_r;
    div_req   = '0;
    mean_we   = 1'b0;
    mean_pre_we = 1'b0;
    mean_wa   = row_r;
    mean_wd   = in_value;
    dev_we    = 1'b0;
    cov_we    = 1'b0;
    cov_pre_we = 1'b0;
    cov_wd    = in_value;
    out_valid_nxt = out_valid_r && !out_ready;
    out_kind_nxt  = out_kind_r;
    out_row_nxt   = out_row_r;
    out_col_nxt   = out_col_r;
    out_value_nxt = out_value_r;
    out_final_nxt = out_final_r;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (in_func)
            ocu_pkg::FN_MEAN: begin
              mean_pre_we = in_row_ok;
            end
            ocu_pkg::FN_COV: begin
              cov_pre_we = in_cov_ok;
            end
            ocu_pkg::FN_SAMPLE: begin
              n_nxt    = n_in;
              last_nxt = in_last;
              row_nxt  = IW'(in_row);
              i_nxt    = '0;
              j_nxt    = '0;
              if (in_row_ok) begin
                neg_nxt          = diff[32];
                div_req.start    = 1'b1;
                div_req.dividend = DW'(diff_mag);
                div_req.divisor  = n_in;
                state_nxt        = ST_SDIV;
              end else if (in_last) begin
                state_nxt = ST_LDU;
              end
            end
            default: begin
              state_nxt = ST_IDLE;
            end
          endcase
        end
      end
      ST_SDIV: begin
        if (div_res.done) begin
          dev_we    = 1'b1;
          mean_we   = 1'b1;
          mean_wd   = ocu_pkg::sat32(mean_w);
          state_nxt = last_r ? ST_LDU : ST_IDLE;
        end
      end
      ST_LDU: begin
        ui_nxt    = dev_rd;
        state_nxt = ST_MUU;
      end
      ST_MUU: begin
        state_nxt = ST_MPH;
      end
      ST_MPH: begin
        pl_nxt    = prod_r[31:0];
        state_nxt = ST_MPL;
      end
      ST_MPL: begin
        hi_nxt    = prod_r[48:0];
        state_nxt = ST_MSN;
      end
      ST_MSN: begin
        lo_nxt    = prod_r[47:0];
        state_nxt = ST_CSTART;
      end
      ST_CSTART: begin
        // floor(p*n / 2^16) from the two partial products
        t2_nxt           = sum81 >>> 16;
        neg_nxt          = prod_r[65];
        div_req.start    = 1'b1;
        div_req.dividend = prod_mag;
        div_req.divisor  = NW'(n_r - NW'(1));
        state_nxt        = ST_CDIV;
      end
      ST_CDIV: begin
        if (div_res.done) begin
          cov_we = 1'b1;
          cov_wd = ocu_pkg::sat32(tot_w);
          if (j_r == IW'(DIM - 1)) begin
            j_nxt = '0;
            if (i_r == IW'(DIM - 1)) begin
              i_nxt     = '0;
              state_nxt = ST_EMEAN;
            end else begin
              i_nxt     = i_r + IW'(1);
              state_nxt = ST_LDU;
            end
          end else begin
            j_nxt     = j_r + IW'(1);
            state_nxt = ST_MUU;
          end
        end
      end
      ST_EMEAN: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = ocu_pkg::KIND_MEAN;
          out_row_nxt   = 2'(i_r);
          out_col_nxt   = '0;
          out_value_nxt = mean_rd;
          out_final_nxt = 1'b0;
          if (i_r == IW'(DIM - 1)) begin
            i_nxt     = '0;
            state_nxt = ST_ECOV;
          end else begin
            i_nxt = i_r + IW'(1);
          end
        end
      end
      ST_ECOV: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = ocu_pkg::KIND_COV;
          out_row_nxt   = 2'(i_r);
          out_col_nxt   = 2'(j_r);
          out_value_nxt = cov_rd;
          out_final_nxt = (i_r == IW'(DIM - 1)) && (j_r == IW'(DIM - 1));
          if (j_r == IW'(DIM - 1)) begin
            j_nxt = '0;
            if (i_r == IW'(DIM - 1)) begin
              i_nxt     = '0;
              state_nxt = ST_IDLE;
            end else begin
              i_nxt = i_r + IW'(1);
            end
          end else begin
            j_nxt = j_r + IW'(1);
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
    if (mean_pre_we) mean_wa = IW'(in_row);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      i_r         <= '0;
      j_r         <= '0;
      for (int a = 0; a < DIM; a++) begin
        mean_r[a] <= '0;
        for (int b = 0; b < DIM; b++) begin
          cov_r[a][b] <= '0;
        end
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      i_r         <= i_nxt;
      j_r         <= j_nxt;
      if (mean_we || mean_pre_we) mean_r[mean_wa] <= mean_wd;
      if (cov_pre_we) cov_r[IW'(in_row)][IW'(in_col)] <= cov_wd;
      else if (cov_we) cov_r[i_r][j_r] <= cov_wd;
    end
    if (dev_we) dev_r[row_r] <= u_val;
    prod_r      <= mul_a * mul_b;
    row_r       <= row_nxt;
    n_r         <= n_nxt;
    last_r      <= last_nxt;
    neg_r       <= neg_nxt;
    ui_r        <= ui_nxt;
    pl_r        <= pl_nxt;
    hi_r        <= hi_nxt;
    lo_r        <= lo_nxt;
    t2_r        <= t2_nxt;
    out_kind_r  <= out_kind_nxt;
    out_row_r   <= out_row_nxt;
    out_col_r   <= out_col_nxt;
    out_value_r <= out_value_nxt;
    out_final_r <= out_final_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_kind        = out_kind_r;
  assign out_row         = out_row_r;
  assign out_col         = out_col_r;
  assign out_value       = out_value_r;
  assign out_final_entry = out_final_r;

endmodule

FILE: tb/online_mean_covariance_update_checker.sv
// Checker for the running mean/covariance update: predicts results and compares them.
module online_mean_covariance_update_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [1:0]         in_func,
  input  logic [1:0]         in_row,
  input  logic [1:0]         in_col,
  input  logic signed [31:0] in_value,
  input  logic [15:0]        in_sample_count,
  input  logic               in_last,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic               out_kind,
  input  logic [1:0]         out_row,
  input  logic [1:0]         out_col,
  input  logic signed [31:0] out_value,
  input  logic               out_final_entry,
  output int                 fail_count,
  output int                 pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int N = ocu_pkg::DIM_DEF;

  typedef struct packed {
    logic              kind;
    logic [1:0]        row;
    logic [1:0]        col;
    logic signed [31:0] value;
    logic              fin;
  } entry_t;

  logic signed [31:0] mean_q[N];
  logic signed [31:0] cov_q[N*N];
  logic signed [31:0] dev_q[N];
  entry_t             entries_due[$];

  function automatic logic signed [31:0] clamp32(longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  // floor division, positive divisor
  function automatic longint fdiv(longint a, longint d);
    longint q;
    q = a / d;
    if ((a % d) != 0 && a < 0) q = q - 1;
    return q;
  endfunction

  task automatic apply_request();
    longint n, s, t1, p, q, r, t2;
    entry_t e;
    n = in_sample_count;
    if (n < 2) n = 2;
    case (in_func)
      ocu_pkg::FN_MEAN: mean_q[in_row] = in_value;
      ocu_pkg::FN_COV:  cov_q[in_row*N + in_col] = in_value;
      ocu_pkg::FN_SAMPLE: begin
        dev_q[in_row] = clamp32((longint'(in_value) - longint'(mean_q[in_row])) / n);
        mean_q[in_row] = clamp32(longint'(mean_q[in_row]) + longint'(dev_q[in_row]));
        if (in_last) begin
          for (int i = 0; i < N; i++)
            for (int j = 0; j < N; j++) begin
              s = cov_q[i*N + j];
              t1 = fdiv(s * (n - 2), n - 1);
              p = longint'(dev_q[i]) * longint'(dev_q[j]);
              q = fdiv(p, 65536);
              r = p - q * 65536;
              t2 = q * n + (r * n) / 65536;
              cov_q[i*N + j] = clamp32(t1 + t2);
            end
          for (int i = 0; i < N; i++) begin
            e = '{ocu_pkg::KIND_MEAN, 2'(i), 2'd0, mean_q[i], 1'b0};
            entries_due.push_back(e);
          end
          for (int i = 0; i < N; i++)
            for (int j = 0; j < N; j++) begin
              e = '{ocu_pkg::KIND_COV, 2'(i), 2'(j), cov_q[i*N + j],
                    (i == N-1 && j == N-1)};
              entries_due.push_back(e);
            end
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    entry_t e;
    if (!rst_n) begin
      fail_count <= 0;
      entries_due.delete();
      for (int i = 0; i < N; i++) begin
        mean_q[i] = '0;
        dev_q[i] = '0;
      end
      for (int i = 0; i < N*N; i++) cov_q[i] = '0;
    end else begin
      if (out_valid && out_ready) begin
        if (entries_due.size() == 0) begin
          if (fail_count < 10) $display("unexpected entry kind %0d [%0d][%0d] %0d",
                                        out_kind, out_row, out_col, out_value);
          fail_count <= fail_count + 1;
        end else begin
          e = entries_due.pop_front();
          if (e.kind !== out_kind || e.row !== out_row || e.col !== out_col ||
              e.value !== out_value || e.fin !== out_final_entry) begin
            if (fail_count < 10)
              $display("mismatch: exp %0d [%0d][%0d] %0d fin %0d, got %0d [%0d][%0d] %0d fin %0d",
                       e.kind, e.row, e.col, e.value, e.fin, out_kind, out_row, out_col,
                       out_value, out_final_entry);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (in_valid && in_ready) apply_request();
    end
    pending <= entries_due.size();
  end
endmodule

FILE: tb/online_mean_covariance_update_tb.sv
// Testbench top: drives requests into the update block and reports the verdict.
module online_mean_covariance_update_tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [1:0]         in_func = '0;
  logic [1:0]         in_row = '0;
  logic [1:0]         in_col = '0;
  logic signed [31:0] in_value = '0;
  logic [15:0]        in_sample_count = 16'd2;
  logic               in_last = 1'b0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic               out_kind;
  logic [1:0]         out_row;
  logic [1:0]         out_col;
  logic signed [31:0] out_value;
  logic               out_final_entry;
  int                 fail_count;
  int                 pending;
  int                 out_wait = 0;
  bit                 stim_done = 1'b0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  online_mean_covariance_update u_top (.*);

  online_mean_covariance_update_checker u_chk (.*);

  // drive one request after a random gap, hold until accepted
  task automatic send(logic [1:0] f, logic [1:0] r, logic [1:0] c, logic [31:0] v,
                      logic [15:0] n, logic l);
    int gap;
    gap = $urandom_range(9);
    if ($urandom_range(3) == 0) gap = 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_func <= f;
    in_row <= r;
    in_col <= c;
    in_value <= v;
    in_sample_count <= n;
    in_last <= l;
    do @(posedge clk); while (!in_ready);
  endtask

  function automatic logic [31:0] rand_value();
    case ($urandom_range(5))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return $urandom_range(32'h40000) - 32'h20000;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [15:0] rand_count();
    case ($urandom_range(5))
      0: return 16'($urandom_range(1));
      1: return 16'hffff;
      2: return 16'($urandom);
      default: return 16'($urandom_range(2, 40));
    endcase
  endfunction

  // full vector of random samples; rows all written so no stale deviation is read
  task automatic send_vector();
    logic [15:0] n;
    n = rand_count();
    for (int i = 0; i < ocu_pkg::DIM_DEF; i++)
      send(ocu_pkg::FN_SAMPLE, 2'(i), 2'($urandom), rand_value(), n,
           i == ocu_pkg::DIM_DEF - 1);
  endtask

  // receiver stalls a drawn number of cycles after each entry
  always @(posedge clk) begin
    int gap;
    if (!rst_n) begin
      out_ready <= 1'b0;
      out_wait <= 0;
    end else if (out_valid && out_ready) begin
      gap = $urandom_range(9);
      out_wait <= gap;
      out_ready <= (gap == 0);
    end else if (!out_ready) begin
      if (out_wait <= 1) out_ready <= 1'b1;
      else out_wait <= out_wait - 1;
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // directed: presets at extremes, unused func code
    send(ocu_pkg::FN_MEAN, 2'd0, 2'd0, 32'h7fffffff, 16'd0, 1'b1);
    send(ocu_pkg::FN_MEAN, 2'd3, 2'd2, 32'h80000000, 16'd5, 1'b0);
    send(ocu_pkg::FN_COV, 2'd0, 2'd0, 32'h7fffffff, 16'd3, 1'b0);
    send(ocu_pkg::FN_COV, 2'd3, 2'd3, 32'h80000000, 16'd3, 1'b1);
    send(ocu_pkg::FN_COV, 2'd1, 2'd2, 32'h00010000, 16'd3, 1'b0);
    send(2'd3, 2'd1, 2'd1, 32'h12345678, 16'd3, 1'b1);
    // small count treated as two, extreme samples
    send(ocu_pkg::FN_SAMPLE, 2'd0, 2'd3, 32'h80000000, 16'd0, 1'b0);
    send(ocu_pkg::FN_SAMPLE, 2'd1, 2'd0, 32'h7fffffff, 16'd1, 1'b0);
    send(ocu_pkg::FN_SAMPLE, 2'd2, 2'd1, 32'h00000000, 16'd1, 1'b0);
    send(ocu_pkg::FN_SAMPLE, 2'd3, 2'd2, 32'hffffffff, 16'd1, 1'b1);
    for (int i = 0; i < ocu_pkg::DIM_DEF; i++)
      send(ocu_pkg::FN_SAMPLE, 2'(i), 2'd0, i[0] ? 32'h7fffffff : 32'h80000000, 16'hffff,
           i == ocu_pkg::DIM_DEF - 1);
    send(ocu_pkg::FN_SAMPLE, 2'd2, 2'd0, 32'h00030000, 16'd2, 1'b1);
    for (int i = 0; i < ocu_pkg::DIM_DEF; i++)
      send(ocu_pkg::FN_SAMPLE, 2'(i), 2'd3, 32'h00008000 * i, 16'd7,
           i == ocu_pkg::DIM_DEF - 1);
    // random part: mostly full vectors, some presets, lone elements and unused func codes
    for (int k = 0; k < 150; k++) begin
      case ($urandom_range(9))
        0: send(ocu_pkg::FN_MEAN, 2'($urandom), 2'($urandom), rand_value(), 16'($urandom),
                1'($urandom));
        1: send(ocu_pkg::FN_COV, 2'($urandom), 2'($urandom), rand_value(), 16'($urandom),
                1'($urandom));
        2: send(ocu_pkg::FN_SAMPLE, 2'($urandom), 2'($urandom), rand_value(), rand_count(),
                1'($urandom_range(1)));
        3: send(2'd3, 2'($urandom), 2'($urandom), $urandom, 16'($urandom), 1'($urandom));
        default: begin
          send_vector();
          k += ocu_pkg::DIM_DEF - 1;
        end
      endcase
    end
    in_valid <= 1'b0;
    stim_done = 1'b1;
  end

  initial begin
    wait (stim_done);
    repeat (2) @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (fail_count == 0 && pending == 0) $display("online_mean_covariance_update_tb OK");
    else $display("online_mean_covariance_update_tb NOT OK");
    $finish;
  end

  initial begin
    #20ms;
    $display("online_mean_covariance_update_tb NOT OK");
    $finish;
  end
endmodule

FILE: files.f
rtl/core/ocu_pkg.sv
rtl/core/ocu_div.sv
rtl/core/online_mean_covariance_update.sv
tb/online_mean_covariance_update_checker.sv
tb/online_mean_covariance_update_tb.sv
